>>> hw/rtl/arpc_pkg.sv
// arpc_pkg: shared types and constants of the arp cache with aging
// holds command/status structs, codes and the entry word layout
// no dependencies
package arpc_pkg;

    // request kinds
    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_LOOKUP = 3'd1;
    localparam logic [2:0] KIND_TICK   = 3'd2;
    localparam logic [2:0] KIND_PURGE  = 3'd3;
    localparam logic [2:0] KIND_FLUSH  = 3'd4;

    // result status codes
    localparam logic [2:0] STS_ADDED   = 3'd0;
    localparam logic [2:0] STS_UPDATED = 3'd1;
    localparam logic [2:0] STS_HIT     = 3'd2;
    localparam logic [2:0] STS_MISS    = 3'd3;
    localparam logic [2:0] STS_DROPPED = 3'd4;
    localparam logic [2:0] STS_DONE    = 3'd5;

    localparam logic [12:0] COUNT_MAX   = 13'd8191;
    localparam logic [31:0] TIMEOUT_RST = 32'd300000;

    // entry word: valid, ip, mac, stamp
    localparam int STAMP_LSB = 0;
    localparam int MAC_LSB   = 32;
    localparam int IP_LSB    = 80;
    localparam int VLD_BIT   = 112;
    localparam int WORD_W    = 113;

    // hash steps
    localparam int OCTET_LAST = 3;
    localparam int MOD_LAST   = 7;

    typedef enum logic [11:0] {
        S_CLR  = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_HASH = 12'b0000_0000_0100,
        S_FIN1 = 12'b0000_0000_1000,
        S_FIN2 = 12'b0000_0001_0000,
        S_MOD  = 12'b0000_0010_0000,
        S_RD   = 12'b0000_0100_0000,
        S_CHK  = 12'b0000_1000_0000,
        S_ACT  = 12'b0001_0000_0000,
        S_SRD  = 12'b0010_0000_0000,
        S_SCHK = 12'b0100_0000_0000,
        S_RESP = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic fin1;
        logic fin2;
        logic mod_step;
        logic rd_scan;
        logic chk;
        logic act;
        logic rd_sweep;
        logic sweep_chk;
        logic clr_wr;
        logic resp;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

>>> hw/rtl/arpc_ram.sv
// arpc_ram: generic simple dual port ram with registered read
// one write port, one read port; no dependencies
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/arpc_ctrl.sv
// arpc_ctrl: sequencer of the arp cache (clear pass, hash, scan, sweep)
// depends on arpc_pkg
module arpc_ctrl #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [2:0]           kind,
    input  arpc_pkg::stat_t      st,
    output logic                 in_ready,
    output arpc_pkg::cmd_t       cmd,
    output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] way,
    output logic [((BUCKETS * WAYS) > 1 ? $clog2(BUCKETS * WAYS) : 1)-1:0] ent
);
    import arpc_pkg::*;

    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int WAY_W   = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int ADDR_W  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

    state_t            state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic [ADDR_W-1:0] ent_reg, ent_next;

    logic way_last, ent_last;
    assign way_last = (way_reg == WAY_W'(WAYS - 1));
    assign ent_last = (ent_reg == ADDR_W'(ENTRIES - 1));

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        way_next   = way_reg;
        ent_next   = ent_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                ent_next   = ent_reg + 1'b1;
                if (ent_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                way_next = '0;
                ent_next = '0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (kind inside {KIND_ADD, KIND_LOOKUP})
                    begin
                        state_next = S_HASH;
                    end
                    else if (kind inside {KIND_PURGE, KIND_FLUSH})
                    begin
                        state_next = S_SRD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == 3'(OCTET_LAST))
                begin
                    cnt_next   = '0;
                    state_next = S_FIN1;
                end
            end
            S_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == 3'(MOD_LAST))
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                cmd.chk = 1'b1;
                if (way_last)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    way_next   = way_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_ACT:
            begin
                cmd.act    = 1'b1;
                state_next = S_RESP;
            end
            S_SRD:
            begin
                cmd.rd_sweep = 1'b1;
                state_next   = S_SCHK;
            end
            S_SCHK:
            begin
                cmd.sweep_chk = 1'b1;
                if (ent_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    ent_next   = ent_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.resp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            way_reg   <= '0;
            ent_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            way_reg   <= way_next;
            ent_reg   <= ent_next;
        end
    end

    assign way = way_reg;
    assign ent = ent_reg;
endmodule

>>> hw/rtl/arpc_dp.sv
// arpc_dp: datapath of the arp cache: hash, bucket reduction, entry store,
// way scan, aging sweep and output register; depends on arpc_pkg, arpc_ram
module arpc_dp #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arpc_pkg::cmd_t       cmd,
    input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] way,
    input  logic [((BUCKETS * WAYS) > 1 ? $clog2(BUCKETS * WAYS) : 1)-1:0] ent,
    input  logic [2:0]           kind,
    input  logic [31:0]          ip,
    input  logic [47:0]          mac,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,
    input  logic                 out_ready,
    output arpc_pkg::stat_t      st,
    output logic                 out_valid,
    output logic [2:0]           status,
    output logic [47:0]          mac_out,
    output logic [12:0]          removed_count
);
    import arpc_pkg::*;

    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int WAY_W   = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int ADDR_W  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
    localparam int BKT_W   = BUCKETS > 1 ? $clog2(BUCKETS) : 1;

    // request registers
    logic [2:0]  kind_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;
    logic [31:0] sh_reg;
    logic [31:0] h_reg;
    logic [BKT_W-1:0] rem_reg;

    // scan results
    logic             found_reg, free_reg;
    logic [WAY_W-1:0] found_way_reg, free_way_reg;
    logic [47:0]      fmac_reg;

    // result registers
    logic [2:0]  res_sts_reg;
    logic [47:0] res_mac_reg;
    logic [12:0] res_cnt_reg;

    // control registers
    logic [31:0] time_reg;
    logic [31:0] timeout_reg;
    logic        out_valid_reg;
    logic [2:0]  out_sts_reg;
    logic [47:0] out_mac_reg;
    logic [12:0] out_cnt_reg;

    // store ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;

    // one octet of the one-at-a-time hash
    logic [31:0] h_oct, h_oct_a;
    always_comb
    begin
        h_oct_a = h_reg + {24'd0, sh_reg[31:24]};
        h_oct_a = h_oct_a + (h_oct_a << 10);
        h_oct   = h_oct_a ^ (h_oct_a >> 6);
    end

    // hash finalization, split into the fin1 and fin2 steps
    logic [31:0] h_f1, h_f1_a, h_f2;
    always_comb
    begin
        h_f1_a = h_reg + (h_reg << 3);
        h_f1   = h_f1_a ^ (h_f1_a >> 11);
        h_f2   = h_reg + (h_reg << 15);
    end

    // bucket reduction, four hash bits per step
    logic [BKT_W-1:0] rem_new;
    logic [BKT_W:0]   rem_x;
    always_comb
    begin
        rem_new = rem_reg;
        rem_x   = '0;
        for (int i = 0; i < 4; i++)
        begin
            rem_x = {rem_new, h_reg[31 - i]};
            if (rem_x >= (BKT_W + 1)'(BUCKETS))
            begin
                rem_x = rem_x - (BKT_W + 1)'(BUCKETS);
            end
            rem_new = rem_x[BKT_W-1:0];
        end
    end

    // entry addresses
    logic [ADDR_W-1:0] bkt_base, scan_addr, act_addr;
    assign bkt_base  = ADDR_W'(rem_reg) * ADDR_W'(WAYS);
    assign scan_addr = bkt_base + ADDR_W'(way);
    assign act_addr  = bkt_base + ADDR_W'(found_reg ? found_way_reg : free_way_reg);

    // fields of the entry read back
    logic        rd_vld;
    logic [31:0] rd_ip, rd_stamp, age;
    logic [47:0] rd_mac;
    logic        sweep_rm;
    assign rd_vld   = rd_data[VLD_BIT];
    assign rd_ip    = rd_data[IP_LSB +: 32];
    assign rd_mac   = rd_data[MAC_LSB +: 48];
    assign rd_stamp = rd_data[STAMP_LSB +: 32];
    assign age      = time_reg - rd_stamp;
    assign sweep_rm = rd_vld && ((kind_reg == KIND_FLUSH) || (age > timeout_reg));

    // store write and read selection
    logic act_wr;
    assign act_wr = cmd.act && (kind_reg == KIND_ADD) && (found_reg || free_reg);
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ent;
        wr_data = '0;
        if (cmd.clr_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.sweep_chk && sweep_rm)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            wr_data[VLD_BIT] = 1'b0;
        end
        else if (act_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = act_addr;
            wr_data = {1'b1, ip_reg, mac_reg, time_reg};
        end
    end
    assign rd_en   = cmd.rd_scan || cmd.rd_sweep;
    assign rd_addr = cmd.rd_sweep ? ent : scan_addr;

    arpc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ENTRIES)
    ) u_store (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // request, hash, scan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            ip_reg      <= ip;
            mac_reg     <= mac;
            sh_reg      <= ip;
            h_reg       <= '0;
            rem_reg     <= '0;
            found_reg   <= 1'b0;
            free_reg    <= 1'b0;
            res_sts_reg <= STS_DONE;
            res_mac_reg <= '0;
            res_cnt_reg <= '0;
        end
        if (cmd.hash_step)
        begin
            h_reg  <= h_oct;
            sh_reg <= {sh_reg[23:0], 8'd0};
        end
        if (cmd.fin1)
        begin
            h_reg <= h_f1;
        end
        if (cmd.fin2)
        begin
            h_reg <= h_f2;
        end
        if (cmd.mod_step)
        begin
            rem_reg <= rem_new;
            h_reg   <= {h_reg[27:0], 4'd0};
        end
        if (cmd.chk)
        begin
            if (rd_vld)
            begin
                if (!found_reg && (rd_ip == ip_reg))
                begin
                    found_reg     <= 1'b1;
                    found_way_reg <= way;
                    fmac_reg      <= rd_mac;
                end
            end
            else if (!free_reg)
            begin
                free_reg     <= 1'b1;
                free_way_reg <= way;
            end
        end
        if (cmd.act)
        begin
            if (kind_reg == KIND_LOOKUP)
            begin
                res_sts_reg <= found_reg ? STS_HIT : STS_MISS;
                res_mac_reg <= found_reg ? fmac_reg : 48'd0;
            end
            else if (found_reg)
            begin
                res_sts_reg <= STS_UPDATED;
            end
            else if (free_reg)
            begin
                res_sts_reg <= STS_ADDED;
            end
            else
            begin
                res_sts_reg <= STS_DROPPED;
            end
        end
        if (cmd.sweep_chk && sweep_rm && (res_cnt_reg != COUNT_MAX))
        begin
            res_cnt_reg <= res_cnt_reg + 1'b1;
        end
    end

    // time, timeout and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            timeout_reg   <= TIMEOUT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && (kind == KIND_TICK))
            begin
                time_reg <= time_reg + 1'b1;
            end
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (cmd.resp)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            out_sts_reg <= res_sts_reg;
            out_mac_reg <= res_mac_reg;
            out_cnt_reg <= res_cnt_reg;
        end
    end

    assign st.out_free    = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign status         = out_sts_reg;
    assign mac_out        = out_mac_reg;
    assign removed_count  = out_cnt_reg;
endmodule

>>> hw/rtl/arp_cache_with_aging_unit.sv
// arp cache with aging: add and lookup run the hash, its finalization, the bucket
// reduction, then a store read and a check per way of the scan before the result
// purge and flush sweep all entries, one store read per entry; tick goes on to
// the result; one request is in work at a time, as in_ready is high only in idle
// after reset a clearing pass over all BUCKETS*WAYS entries holds in_ready low
// depends on arpc_pkg, arpc_ctrl, arpc_dp
module arp_cache_with_aging_unit #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [31:0] ip,
    input  logic [47:0] mac,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [47:0] mac_out,
    output logic [12:0] removed_count,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import arpc_pkg::*;

    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int WAY_W   = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int ADDR_W  = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

    cmd_t              cmd;
    stat_t             st;
    logic [WAY_W-1:0]  way;
    logic [ADDR_W-1:0] ent;

    // sequencer
    arpc_ctrl #(
        .BUCKETS(BUCKETS),
        .WAYS   (WAYS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .kind    (kind),
        .st      (st),
        .in_ready(in_ready),
        .cmd     (cmd),
        .way     (way),
        .ent     (ent)
    );

    // datapath
    arpc_dp #(
        .BUCKETS(BUCKETS),
        .WAYS   (WAYS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .way          (way),
        .ent          (ent),
        .kind         (kind),
        .ip           (ip),
        .mac          (mac),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (out_ready),
        .st           (st),
        .out_valid    (out_valid),
        .status       (status),
        .mac_out      (mac_out),
        .removed_count(removed_count)
    );
endmodule

>>> hw/rtl/arpc_chk.sv
// arpc_chk: port level checks of the arp cache, bound to the top level
// depends on arpc_pkg
module arpc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [47:0] mac_out,
    input logic [12:0] removed_count
);
    import arpc_pkg::*;

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its status
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status))
        else $error("status changed while stalled");

    // status codes stay in range
    a_sts_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STS_DONE)
        else $error("status code out of range");

    // mac only on a lookup hit
    a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STS_HIT) |-> mac_out == 48'd0)
        else $error("mac on a result other than a hit");

    // count only on a done result
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STS_DONE) |-> removed_count == 13'd0)
        else $error("removed count on an add or lookup result");
endmodule

bind arp_cache_with_aging_unit arpc_chk u_chk (.*);

>>> verif/tb_arp_cache_with_aging_unit.sv
// tb_arp_cache_with_aging_unit: self-checking testbench of the arp cache with aging
// directed table then random requests, each checked against an in-bench cache predictor
// depends on arpc_pkg and arp_cache_with_aging_unit
module tb_arp_cache_with_aging_unit;
    import arpc_pkg::*;

    localparam int NBUCKET = 1024;
    localparam int NWAY    = 4;
    localparam int NENTRY  = NBUCKET * NWAY;
    localparam int SWEEP_WAIT = 2 * NENTRY + 40;
    localparam longint CYCLE_LIMIT = 64'd20000000;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        known;
        logic [2:0]  sts;
        logic [47:0] mac_res;
        logic [12:0] cnt;
    } row_t;

    typedef struct {
        logic [2:0]  sts;
        logic [47:0] mac_res;
        logic [12:0] cnt;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [47:0] mac_out;
    logic [12:0] removed_count;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    // predictor state
    logic        cache_vld[NENTRY];
    logic [31:0] cache_ip[NENTRY];
    logic [47:0] cache_mac[NENTRY];
    logic [31:0] cache_stamp[NENTRY];
    logic [31:0] now_ticks;
    logic [31:0] timeout_val;

    answer_t pending[$];
    logic [31:0] known_ips[$];
    int      errors;
    longint  cycles;

    arp_cache_with_aging_unit #(.BUCKETS(NBUCKET), .WAYS(NWAY)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .ip(ip), .mac(mac),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .mac_out(mac_out), .removed_count(removed_count),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // one-at-a-time hash of the octets, msb first
    function automatic int bucket_index(logic [31:0] addr);
        logic [31:0] h;
        h = 32'd0;
        for (int k = 3; k >= 0; k--)
        begin
            h = h + addr[8*k +: 8];
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return int'(h % NBUCKET);
    endfunction

    // remove entries, all or only aged ones, saturating count
    function automatic logic [12:0] sweep_cache(logic aged_only);
        int n;
        n = 0;
        for (int e = 0; e < NENTRY; e++)
        begin
            if (cache_vld[e] && !(aged_only && (now_ticks - cache_stamp[e]) <= timeout_val))
            begin
                cache_vld[e] = 1'b0;
                n++;
            end
        end
        return (n > 8191) ? COUNT_MAX : 13'(n);
    endfunction

    // expected answer of one request, updates the predicted cache
    function automatic answer_t cache_answer(logic [2:0] k, logic [31:0] a, logic [47:0] m);
        answer_t r;
        int base;
        int found;
        int free_way;
        r.sts = STS_DONE;
        r.mac_res = '0;
        r.cnt = '0;
        if (k == KIND_ADD || k == KIND_LOOKUP)
        begin
            base = bucket_index(a) * NWAY;
            found = -1;
            free_way = -1;
            for (int w = 0; w < NWAY; w++)
            begin
                if (cache_vld[base + w])
                begin
                    if (found < 0 && cache_ip[base + w] == a)
                        found = base + w;
                end
                else if (free_way < 0)
                    free_way = base + w;
            end
            if (k == KIND_LOOKUP)
            begin
                if (found >= 0)
                begin
                    r.sts = STS_HIT;
                    r.mac_res = cache_mac[found];
                end
                else
                    r.sts = STS_MISS;
            end
            else if (found >= 0)
            begin
                cache_mac[found] = m;
                cache_stamp[found] = now_ticks;
                r.sts = STS_UPDATED;
            end
            else if (free_way >= 0)
            begin
                cache_vld[free_way] = 1'b1;
                cache_ip[free_way] = a;
                cache_mac[free_way] = m;
                cache_stamp[free_way] = now_ticks;
                r.sts = STS_ADDED;
            end
            else
                r.sts = STS_DROPPED;
        end
        else if (k == KIND_TICK)
            now_ticks = now_ticks + 32'd1;
        else if (k == KIND_PURGE)
            r.cnt = sweep_cache(1'b1);
        else if (k == KIND_FLUSH)
            r.cnt = sweep_cache(1'b0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // send one request; typed expectation checked against the predictor too
    // valid is dropped at the start of a gap, or by drain after the last request
    task automatic send_request(logic [2:0] k, logic [31:0] a, logic [47:0] m,
                                logic known, answer_t typed);
        answer_t exp_ans;
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        ip <= a;
        mac <= m;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        exp_ans = cache_answer(k, a, m);
        if (known && (exp_ans.sts !== typed.sts || exp_ans.mac_res !== typed.mac_res
                      || exp_ans.cnt !== typed.cnt))
            report_mismatch("table entry", {61'd0, typed.sts}, {61'd0, exp_ans.sts});
        pending.push_back(exp_ans);
        if (k == KIND_ADD)
            known_ips.push_back(a);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_timeout(logic [31:0] v);
        drain();
        repeat (SWEEP_WAIT) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        timeout_val = v;
    endtask

    // result checker and receiver stall
    int stall_left;
    always @(posedge clk)
    begin
        answer_t head;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending.size() == 0)
                    report_mismatch("unexpected result", 64'(status), 64'd0);
                else
                begin
                    head = pending.pop_front();
                    if (status !== head.sts)
                        report_mismatch("status", 64'(status), 64'(head.sts));
                    if (mac_out !== head.mac_res)
                        report_mismatch("mac_out", 64'(mac_out), 64'(head.mac_res));
                    if (removed_count !== head.cnt)
                        report_mismatch("removed_count", 64'(removed_count), 64'(head.cnt));
                end
                stall_left = $urandom_range(0, 18);
                if ($urandom_range(0, 3) == 0)
                    stall_left = 0;
            end
            else if (stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0) || (out_valid && out_ready && stall_left == 0);
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_ip();
        int i;
        if (known_ips.size() != 0 && $urandom_range(0, 2) != 0)
        begin
            i = $urandom_range(0, known_ips.size() - 1);
            return known_ips[i];
        end
        return $urandom();
    endfunction

    // addresses that share the bucket of 0, to fill a bucket
    logic [31:0] same_bucket[$];
    row_t        table_rows[$];

    initial
    begin
        row_t r;
        answer_t none;
        logic [2:0] k;
        int sel;
        errors = 0;
        cycles = 0;
        stall_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        ip = '0;
        mac = '0;
        out_ready = 1'b1;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        for (int e = 0; e < NENTRY; e++)
        begin
            cache_vld[e] = 1'b0;
            cache_ip[e] = '0;
            cache_mac[e] = '0;
            cache_stamp[e] = '0;
        end
        now_ticks = '0;
        timeout_val = TIMEOUT_RST;
        none.sts = STS_DONE;
        none.mac_res = '0;
        none.cnt = '0;

        same_bucket.push_back(32'd0);
        for (logic [31:0] a = 1; same_bucket.size() < NWAY + 1; a++)
            if (bucket_index(a) == bucket_index(32'd0))
                same_bucket.push_back(a);

        // directed table: typed answers where obvious
        table_rows = '{
            '{KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1, STS_MISS, 48'h0, 13'd0},
            '{KIND_PURGE,  32'h0, 48'h0, 1'b1, STS_DONE, 48'h0, 13'd0},
            '{KIND_ADD,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, STS_ADDED, 48'h0, 13'd0},
            '{KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1, STS_HIT, 48'hFFFF_FFFF_FFFF, 13'd0},
            '{KIND_ADD,    32'hFFFF_FFFF, 48'h0, 1'b1, STS_UPDATED, 48'h0, 13'd0},
            '{KIND_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1, STS_HIT, 48'h0, 13'd0},
            '{3'd5, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, STS_DONE, 48'h0, 13'd0},
            '{3'd6, 32'h0, 48'h0, 1'b1, STS_DONE, 48'h0, 13'd0},
            '{3'd7, 32'h1234_5678, 48'h1, 1'b1, STS_DONE, 48'h0, 13'd0},
            '{KIND_TICK,   32'h0, 48'h0, 1'b1, STS_DONE, 48'h0, 13'd0},
            '{KIND_ADD,    same_bucket[0], 48'hA0, 1'b0, 3'd0, 48'h0, 13'd0},
            '{KIND_ADD,    same_bucket[1], 48'hA1, 1'b0, 3'd0, 48'h0, 13'd0},
            '{KIND_ADD,    same_bucket[2], 48'hA2, 1'b0, 3'd0, 48'h0, 13'd0},
            '{KIND_ADD,    same_bucket[3], 48'hA3, 1'b0, 3'd0, 48'h0, 13'd0},
            '{KIND_ADD,    same_bucket[4], 48'hA4, 1'b1, STS_DROPPED, 48'h0, 13'd0},
            '{KIND_LOOKUP, same_bucket[4], 48'h0, 1'b1, STS_MISS, 48'h0, 13'd0},
            '{KIND_LOOKUP, same_bucket[2], 48'h0, 1'b0, 3'd0, 48'h0, 13'd0},
            '{KIND_PURGE,  32'h0, 48'h0, 1'b0, 3'd0, 48'h0, 13'd0},
            '{KIND_FLUSH,  32'h0, 48'h0, 1'b1, STS_DONE, 48'h0, 13'd5},
            '{KIND_LOOKUP, same_bucket[0], 48'h0, 1'b1, STS_MISS, 48'h0, 13'd0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
        begin
            r = table_rows[i];
            none.sts = r.sts;
            none.mac_res = r.mac_res;
            none.cnt = r.cnt;
            send_request(r.kind, r.ip, r.mac, r.known, none);
        end
        none.sts = STS_DONE;
        none.mac_res = '0;
        none.cnt = '0;

        // random phases over timeout settings, extremes among them
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_timeout(32'd1);
                1: write_timeout(32'd3);
                2: write_timeout(32'hFFFF_FFFF);
                3: write_timeout($urandom_range(1, 20));
                4: write_timeout(32'd0 + TIMEOUT_RST);
                default: write_timeout(32'd2);
            endcase
            for (int n = 0; n < 75; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    k = KIND_ADD;
                else if (sel < 75)
                    k = KIND_LOOKUP;
                else if (sel < 92)
                    k = KIND_TICK;
                else if (sel < 96)
                    k = KIND_PURGE;
                else if (sel < 97)
                    k = KIND_FLUSH;
                else
                    k = 3'($urandom_range(5, 7));
                send_request(k, pick_ip(), {$urandom(), $urandom()} , 1'b0, none);
                if (n == 30)
                    drain();
            end
        end

        // time wrap: preset the tick count far up via many ticks is too slow, so
        // the counter is only checked near zero; purge with max timeout already done
        drain();
        repeat (SWEEP_WAIT) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
